// File: rtl/core/btd_pkg.sv
// ----------------------------------------------------------------------------
// btd_pkg
// Shared types and constants of the broadcast table divide unit.
// ----------------------------------------------------------------------------
package btd_pkg;

    localparam int DATA_W     = 64;
    localparam int ADDR_IN_W  = 12;
    localparam int CFG_IDX_W  = 2;
    localparam int NUM_DIMS_W = 4;
    localparam int MASK_W     = 8;

    localparam logic [CFG_IDX_W-1:0] REG_NUM_DIMS   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DIM_SIZES  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SMALL_MASK = 2'd2;

    localparam logic MODE_WRITE  = 1'b0;
    localparam logic MODE_DIVIDE = 1'b1;

    localparam logic [DATA_W-1:0] FP_ONE         = 64'h3FF0_0000_0000_0000;
    localparam logic [DATA_W-1:0] FP_DEFAULT_NAN = 64'hFFF8_0000_0000_0000;
    localparam logic [DATA_W-1:0] FP_QUIET_BIT   = 64'h0008_0000_0000_0000;

    typedef struct packed {
        logic latch;
        logic addr_start;
        logic mem_write;
        logic mem_read;
        logic unit_start;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic addr_busy;
        logic div_busy;
        logic odo_busy;
    } t_status;

endpackage

// File: rtl/core/btd_fdiv.sv
// ----------------------------------------------------------------------------
// btd_fdiv
// Iterative IEEE double divider with round to nearest even and subnormals.
// ----------------------------------------------------------------------------
module btd_fdiv
    import btd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_start,
    input  logic [DATA_W-1:0] i_num,
    input  logic [DATA_W-1:0] i_den,
    output logic              o_busy,
    output logic [DATA_W-1:0] o_result
);

    localparam int QBITS = 55;
    localparam logic signed [13:0] EXP_BIAS = 14'sd1023;
    localparam logic signed [13:0] EXP_MAX  = 14'sd2047;

    typedef enum logic [2:0] {D_IDLE, D_NORM, D_DIV, D_ALIGN, D_SHIFT, D_ROUND} t_dstate;

    t_dstate                r_state;
    logic                   r_sign;
    logic [52:0]            r_ma;
    logic [52:0]            r_mb;
    logic signed [13:0]     r_ea;
    logic signed [13:0]     r_eb;
    logic signed [13:0]     r_exp;
    logic [53:0]            r_rem;
    logic [QBITS-1:0]       r_q;
    logic [5:0]             r_cnt;
    logic [54:0]            r_vec;
    logic [DATA_W-1:0]      r_res;

    logic [DATA_W-1:0] den_eff;
    logic [10:0]       ne;
    logic [10:0]       de;
    logic              num_nan;
    logic              den_nan;
    logic              num_inf;
    logic              den_inf;
    logic              num_zero;
    logic              sign_q;
    logic              ge;
    logic [53:0]       diff;
    logic [52:0]       mant;
    logic              inc;
    logic [53:0]       sum;
    logic [52:0]       mant2;
    logic signed [13:0] e2;
    logic              ovf;
    logic [10:0]       field;

    always_comb begin
        den_eff  = (i_den[62:0] == 63'd0) ? FP_ONE : i_den;
        ne       = i_num[62:52];
        de       = den_eff[62:52];
        num_nan  = (ne == 11'h7FF) && (i_num[51:0] != 52'd0);
        den_nan  = (de == 11'h7FF) && (den_eff[51:0] != 52'd0);
        num_inf  = (ne == 11'h7FF) && (i_num[51:0] == 52'd0);
        den_inf  = (de == 11'h7FF) && (den_eff[51:0] == 52'd0);
        num_zero = (ne == 11'd0) && (i_num[51:0] == 52'd0);
        sign_q   = i_num[63] ^ den_eff[63];
        ge       = r_rem >= {1'b0, r_mb};
        diff     = r_rem - {1'b0, r_mb};
        mant     = r_vec[54:2];
        inc      = r_vec[1] & (r_vec[0] | mant[0]);
        sum      = {1'b0, mant} + {53'd0, inc};
        mant2    = sum[53] ? sum[53:1] : sum[52:0];
        e2       = sum[53] ? (r_exp + 14'sd1) : r_exp;
        ovf      = e2 >= EXP_MAX;
        field    = mant2[52] ? e2[10:0] : 11'd0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= D_IDLE;
        end else begin
            unique case (r_state)
                D_IDLE: begin
                    if (i_start) begin
                        r_sign <= sign_q;
                        if (num_nan) begin
                            r_res <= i_num | FP_QUIET_BIT;
                        end else if (den_nan) begin
                            r_res <= den_eff | FP_QUIET_BIT;
                        end else if (num_inf && den_inf) begin
                            r_res <= FP_DEFAULT_NAN;
                        end else if (num_inf) begin
                            r_res <= {sign_q, 11'h7FF, 52'd0};
                        end else if (den_inf || num_zero) begin
                            r_res <= {sign_q, 63'd0};
                        end else begin
                            r_ma    <= {ne != 11'd0, i_num[51:0]};
                            r_mb    <= {de != 11'd0, den_eff[51:0]};
                            r_ea    <= (ne == 11'd0) ? 14'sd1 : $signed({3'b000, ne});
                            r_eb    <= (de == 11'd0) ? 14'sd1 : $signed({3'b000, de});
                            r_state <= D_NORM;
                        end
                    end
                end
                D_NORM: begin
                    if (r_ma[52] && r_mb[52]) begin
                        r_exp   <= r_ea - r_eb + EXP_BIAS;
                        r_rem   <= {1'b0, r_ma};
                        r_q     <= '0;
                        r_cnt   <= 6'(QBITS - 1);
                        r_state <= D_DIV;
                    end else begin
                        if (!r_ma[52]) begin
                            r_ma <= {r_ma[51:0], 1'b0};
                            r_ea <= r_ea - 14'sd1;
                        end
                        if (!r_mb[52]) begin
                            r_mb <= {r_mb[51:0], 1'b0};
                            r_eb <= r_eb - 14'sd1;
                        end
                    end
                end
                D_DIV: begin
                    r_q   <= {r_q[QBITS-2:0], ge};
                    r_rem <= ge ? {diff[52:0], 1'b0} : {r_rem[52:0], 1'b0};
                    if (r_cnt == 6'd0) begin
                        r_state <= D_ALIGN;
                    end else begin
                        r_cnt <= r_cnt - 6'd1;
                    end
                end
                D_ALIGN: begin
                    if (r_q[54]) begin
                        r_vec <= {r_q[54:2], r_q[1], r_q[0] | (r_rem != 54'd0)};
                    end else begin
                        r_vec <= {r_q[53:1], r_q[0], r_rem != 54'd0};
                        r_exp <= r_exp - 14'sd1;
                    end
                    r_state <= D_SHIFT;
                end
                D_SHIFT: begin
                    if (r_exp >= 14'sd1 || r_vec[54:1] == 54'd0) begin
                        r_state <= D_ROUND;
                    end else begin
                        r_vec <= {1'b0, r_vec[54:2], r_vec[1] | r_vec[0]};
                        r_exp <= r_exp + 14'sd1;
                    end
                end
                D_ROUND: begin
                    if (ovf) begin
                        r_res <= {r_sign, 11'h7FF, 52'd0};
                    end else begin
                        r_res <= {r_sign, field, mant2[51:0]};
                    end
                    r_state <= D_IDLE;
                end
                default: r_state <= D_IDLE;
            endcase
        end
    end

    assign o_busy   = r_state != D_IDLE;
    assign o_result = r_res;

endmodule

// File: rtl/core/btd_odo.sv
// ----------------------------------------------------------------------------
// btd_odo
// Dimension odometer that tracks the small-table index modulo its depth.
// ----------------------------------------------------------------------------
module btd_odo
    import btd_pkg::*;
#(
    parameter int MAX_DIMS    = 8,
    parameter int SMALL_DEPTH = 4096,
    parameter int SIZE_BITS   = 8
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic                           i_clear,
    input  logic [NUM_DIMS_W-1:0]          i_num_dims,
    input  logic [DATA_W-1:0]              i_sizes,
    input  logic [MASK_W-1:0]              i_mask,
    output logic                           o_busy,
    output logic [$clog2(SMALL_DEPTH)-1:0] o_index
);

    localparam int ADDR_W = $clog2(SMALL_DEPTH);
    localparam int DIM_W  = (MAX_DIMS > 1) ? $clog2(MAX_DIMS) : 1;
    localparam int NW     = DIM_W + 1;
    localparam int BIT_W  = $clog2(SIZE_BITS + 1);
    localparam logic [ADDR_W:0] DEPTH_V = (ADDR_W + 1)'(SMALL_DEPTH);

    typedef enum logic [1:0] {O_IDLE, O_DIM, O_MUL, O_ACC} t_ostate;

    t_ostate               r_state;
    logic [SIZE_BITS-1:0]  r_cnt [MAX_DIMS];
    logic [NW-1:0]         r_d;
    logic [ADDR_W-1:0]     r_acc;
    logic [ADDR_W-1:0]     r_stride;
    logic [ADDR_W-1:0]     r_p1;
    logic [ADDR_W-1:0]     r_p2;
    logic [SIZE_BITS:0]    r_m1;
    logic [SIZE_BITS:0]    r_m2;
    logic [BIT_W-1:0]      r_bit;
    logic [ADDR_W-1:0]     r_index;

    logic [NW-1:0]         n;
    logic [SIZE_BITS-1:0]  nxt [MAX_DIMS];
    logic [SIZE_BITS-1:0]  top_d;
    logic [ADDR_W-1:0]     p1_dbl;
    logic [ADDR_W-1:0]     p2_dbl;
    logic [ADDR_W-1:0]     p1_nxt;
    logic [ADDR_W-1:0]     p2_nxt;

    function automatic logic [ADDR_W-1:0] addmod(input logic [ADDR_W-1:0] a,
                                                 input logic [ADDR_W-1:0] b);
        logic [ADDR_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        if (s >= DEPTH_V) begin
            s = s - DEPTH_V;
        end
        return s[ADDR_W-1:0];
    endfunction

    always_comb begin
        logic carry;
        logic [SIZE_BITS-1:0] base;
        if (i_num_dims == '0) begin
            n = NW'(1);
        end else if (32'(i_num_dims) > MAX_DIMS) begin
            n = NW'(MAX_DIMS);
        end else begin
            n = NW'(i_num_dims);
        end
        carry = 1'b1;
        for (int d = 0; d < MAX_DIMS; d++) begin
            base   = i_clear ? '0 : r_cnt[d];
            nxt[d] = base;
            if (carry && (NW'(d) < n)) begin
                if (base >= i_sizes[d*SIZE_BITS +: SIZE_BITS]) begin
                    nxt[d] = '0;
                end else begin
                    nxt[d] = base + SIZE_BITS'(1);
                    carry  = 1'b0;
                end
            end
        end
        top_d  = i_sizes[r_d[DIM_W-1:0]*SIZE_BITS +: SIZE_BITS];
        p1_dbl = addmod(r_p1, r_p1);
        p2_dbl = addmod(r_p2, r_p2);
        p1_nxt = r_m1[r_bit] ? addmod(p1_dbl, r_stride) : p1_dbl;
        p2_nxt = r_m2[r_bit] ? addmod(p2_dbl, r_stride) : p2_dbl;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= O_IDLE;
            r_index <= '0;
            for (int d = 0; d < MAX_DIMS; d++) begin
                r_cnt[d] <= '0;
            end
        end else begin
            unique case (r_state)
                O_IDLE: begin
                    if (i_start) begin
                        r_cnt    <= nxt;
                        r_d      <= '0;
                        r_acc    <= '0;
                        r_stride <= ADDR_W'(1);
                        r_state  <= O_DIM;
                    end
                end
                O_DIM: begin
                    if (r_d == n) begin
                        r_index <= r_acc;
                        r_state <= O_IDLE;
                    end else if (i_mask[r_d[DIM_W-1:0]]) begin
                        r_p1    <= '0;
                        r_p2    <= '0;
                        r_m1    <= {1'b0, r_cnt[r_d[DIM_W-1:0]]};
                        r_m2    <= {1'b0, top_d} + (SIZE_BITS + 1)'(1);
                        r_bit   <= BIT_W'(SIZE_BITS);
                        r_state <= O_MUL;
                    end else begin
                        r_d <= r_d + NW'(1);
                    end
                end
                O_MUL: begin
                    r_p1 <= p1_nxt;
                    r_p2 <= p2_nxt;
                    if (r_bit == '0) begin
                        r_state <= O_ACC;
                    end else begin
                        r_bit <= r_bit - BIT_W'(1);
                    end
                end
                O_ACC: begin
                    r_acc    <= addmod(r_acc, r_p1);
                    r_stride <= r_p2;
                    r_d      <= r_d + NW'(1);
                    r_state  <= O_DIM;
                end
                default: r_state <= O_IDLE;
            endcase
        end
    end

    assign o_busy  = r_state != O_IDLE;
    assign o_index = r_index;

endmodule

// File: rtl/core/btd_dpath.sv
// ----------------------------------------------------------------------------
// btd_dpath
// Datapath: configuration registers, small-table memory, address reduction,
// odometer, divider and result register.
// ----------------------------------------------------------------------------
module btd_dpath
    import btd_pkg::*;
#(
    parameter int MAX_DIMS    = 8,
    parameter int SMALL_DEPTH = 4096,
    parameter int SIZE_BITS   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic [ADDR_IN_W-1:0] i_small_addr,
    input  logic [DATA_W-1:0]    i_operand,
    input  logic                 i_first,
    input  t_cmd                 i_cmd,
    output t_status              o_status,
    output logic [DATA_W-1:0]    o_quotient
);

    localparam int ADDR_W   = $clog2(SMALL_DEPTH);
    localparam int RECIP_SH = 24;
    localparam int PROD_W   = ADDR_IN_W + RECIP_SH;
    localparam logic [RECIP_SH-1:0] RECIP =
        RECIP_SH'(((64'd1 << RECIP_SH) + 64'(SMALL_DEPTH) - 64'd1) / 64'(SMALL_DEPTH));

    logic [NUM_DIMS_W-1:0] r_num_dims;
    logic [DATA_W-1:0]     r_dim_sizes;
    logic [MASK_W-1:0]     r_mask;
    logic [DATA_W-1:0]     r_operand;
    logic                  r_first;
    logic [ADDR_IN_W-1:0]  r_addr;
    logic [ADDR_W-1:0]     r_aacc;
    logic [ADDR_IN_W-1:0]  r_aq;
    logic                  r_abusy;
    logic [DATA_W-1:0]     r_rdata;
    logic [DATA_W-1:0]     r_quotient;
    logic [DATA_W-1:0]     r_mem [SMALL_DEPTH];

    logic [ADDR_W-1:0]     odo_index;
    logic [ADDR_W-1:0]     rd_addr;
    logic [DATA_W-1:0]     div_result;
    logic                  div_busy;
    logic                  odo_busy;
    logic [PROD_W-1:0]     aprod;
    logic [ADDR_IN_W-1:0]  arem;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_num_dims  <= NUM_DIMS_W'(1);
            r_dim_sizes <= '0;
            r_mask      <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_NUM_DIMS:   r_num_dims  <= i_cfg_data[NUM_DIMS_W-1:0];
                REG_DIM_SIZES:  r_dim_sizes <= i_cfg_data;
                REG_SMALL_MASK: r_mask      <= i_cfg_data[MASK_W-1:0];
                default: ;
            endcase
        end
    end

    assign aprod = PROD_W'(i_small_addr) * PROD_W'(RECIP);
    assign arem  = r_addr - ADDR_IN_W'(32'(r_aq) * SMALL_DEPTH);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_abusy <= 1'b0;
        end else if (i_cmd.addr_start) begin
            r_abusy <= 1'b1;
            r_aq    <= aprod[PROD_W-1:RECIP_SH];
        end else if (r_abusy) begin
            r_aacc  <= ADDR_W'(arem);
            r_abusy <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.latch) begin
            r_operand <= i_operand;
            r_first   <= i_first;
            r_addr    <= i_small_addr;
        end
        if (i_cmd.out_load) begin
            r_quotient <= div_result;
        end
    end

    assign rd_addr = r_first ? '0 : odo_index;

    always_ff @(posedge i_clk) begin
        if (i_cmd.mem_write) begin
            r_mem[r_aacc] <= r_operand;
        end
        if (i_cmd.mem_read) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    btd_fdiv u_fdiv (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_cmd.unit_start),
        .i_num    (r_operand),
        .i_den    (r_rdata),
        .o_busy   (div_busy),
        .o_result (div_result)
    );

    btd_odo #(
        .MAX_DIMS    (MAX_DIMS),
        .SMALL_DEPTH (SMALL_DEPTH),
        .SIZE_BITS   (SIZE_BITS)
    ) u_odo (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (i_cmd.unit_start),
        .i_clear    (r_first),
        .i_num_dims (r_num_dims),
        .i_sizes    (r_dim_sizes),
        .i_mask     (r_mask),
        .o_busy     (odo_busy),
        .o_index    (odo_index)
    );

    assign o_status.addr_busy = r_abusy;
    assign o_status.div_busy  = div_busy;
    assign o_status.odo_busy  = odo_busy;
    assign o_quotient         = r_quotient;

endmodule

// File: rtl/core/btd_ctrl.sv
// ----------------------------------------------------------------------------
// btd_ctrl
// Controller that sequences table writes and divisions and owns the
// output valid flag.
// ----------------------------------------------------------------------------
module btd_ctrl
    import btd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    input  logic    i_mode,
    input  logic    i_out_stall,
    input  t_status i_status,
    output logic    o_in_stall,
    output logic    o_out_valid,
    output t_cmd    o_cmd
);

    typedef enum logic [2:0] {S_IDLE, S_ADDR, S_WRITE, S_READ, S_START, S_RUN} t_state;

    t_state r_state;
    logic   r_out_valid;
    logic   accept;
    logic   can_load;
    logic   done;

    always_comb begin
        accept           = i_in_valid && (r_state == S_IDLE);
        can_load         = !r_out_valid || !i_out_stall;
        done             = !i_status.div_busy && !i_status.odo_busy;
        o_cmd.latch      = accept;
        o_cmd.addr_start = accept && (i_mode == MODE_WRITE);
        o_cmd.mem_write  = r_state == S_WRITE;
        o_cmd.mem_read   = r_state == S_READ;
        o_cmd.unit_start = r_state == S_START;
        o_cmd.out_load   = (r_state == S_RUN) && done && can_load;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            if (o_cmd.out_load) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        r_state <= (i_mode == MODE_WRITE) ? S_ADDR : S_READ;
                    end
                end
                S_ADDR: begin
                    if (!i_status.addr_busy) begin
                        r_state <= S_WRITE;
                    end
                end
                S_WRITE: r_state <= S_IDLE;
                S_READ:  r_state <= S_START;
                S_START: r_state <= S_RUN;
                S_RUN: begin
                    if (done && can_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    assign o_in_stall  = r_state != S_IDLE;
    assign o_out_valid = r_out_valid;

    a_odo_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_START) |=> i_status.odo_busy)
        else $error("Odometer did not start with the division.");

    a_addr_started: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_mode == MODE_WRITE)) |=> i_status.addr_busy)
        else $error("Address reduction did not start on a table write.");

    a_write_after_reduce: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.mem_write |-> !i_status.addr_busy)
        else $error("Table written before its address was reduced.");

    a_result_from_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == S_RUN))
        else $error("Result appeared without a finished division.");

endmodule

// File: rtl/core/broadcast_table_divide_unit.sv
// ----------------------------------------------------------------------------
// broadcast_table_divide_unit
// Divides streamed big-table entries by a broadcast small table of doubles.
// ----------------------------------------------------------------------------
// Usage: configure num_dims, dim_sizes_minus_one and small_dim_mask through
// the write port while idle, then load the small table with mode 0 transfers
// and stream the big table in column-major order with mode 1 transfers,
// raising first on the first entry.
// Input channel: i_in_valid / o_in_stall. One item is in work at a time.
// Output channel: o_out_valid / i_out_stall with a result register, so the
// next item is taken while a result still waits.
// In a mode 0 transfer the address is reduced by a reciprocal multiplication,
// the quotient and then the remainder registered, before the table write. The
// time of a mode 1 transfer is set by the divider: up to 52 normalization
// steps, 55 quotient bits, up to 54 subnormal shifts and a rounding step, all
// skipped for special operands; the odometer runs alongside with modular
// multiplies per masked dimension, which can set the time of a short division.
// Reset clears the odometer, the small-table index and the configuration
// registers (num_dims to one); the table contents are undefined until written.
// While the receiver stalls, the result stays; a finished division waits.
// ----------------------------------------------------------------------------
module broadcast_table_divide_unit
    import btd_pkg::*;
#(
    parameter int MAX_DIMS    = 8,
    parameter int SMALL_DEPTH = 4096,
    parameter int SIZE_BITS   = 8
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_we,
    input  logic [CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [DATA_W-1:0]    i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic                 i_mode,
    input  logic [ADDR_IN_W-1:0] i_small_addr,
    input  logic [DATA_W-1:0]    i_operand,
    input  logic                 i_first,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [DATA_W-1:0]    o_quotient
);

    t_cmd    cmd;
    t_status status;

    btd_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .i_mode      (i_mode),
        .i_out_stall (i_out_stall),
        .i_status    (status),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_cmd       (cmd)
    );

    btd_dpath #(
        .MAX_DIMS    (MAX_DIMS),
        .SMALL_DEPTH (SMALL_DEPTH),
        .SIZE_BITS   (SIZE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .i_small_addr (i_small_addr),
        .i_operand    (i_operand),
        .i_first      (i_first),
        .i_cmd        (cmd),
        .o_status     (status),
        .o_quotient   (o_quotient)
    );

endmodule
